FILE: rtl/dcss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dcss_pkg;

	// Register indexes of the configuration port
	localparam logic CFG_TICKS_PER_SECOND = 1'b0;
	localparam logic CFG_DEBOUNCE_ITEMS   = 1'b1;

	localparam logic [7:0] TICKS_PER_SECOND_RESET = 8'd100;
	localparam logic [7:0] DEBOUNCE_ITEMS_RESET   = 8'd10;

	localparam logic [4:0] HOUR_RESET = 5'd12;
	localparam logic [4:0] HOUR_MAX   = 5'd23;
	localparam logic [5:0] MINSEC_MAX = 6'd59;

	localparam logic [7:0] SEG_DASH  = 8'hbf;
	localparam logic [7:0] SEG_BLANK = 8'hff;

	typedef struct packed {
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
	} clock_time_t;

	// Accepted key changes that act on the time
	typedef struct packed {
		logic hour_bump;
		logic minute_bump;
	} key_evt_t;

	typedef struct packed {
		logic [2:0] tens;
		logic [3:0] ones;
	} dec_t;

	function automatic logic [7:0] seg_of(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0:    s = 8'hc0;
			4'd1:    s = 8'hf9;
			4'd2:    s = 8'ha4;
			4'd3:    s = 8'hb0;
			4'd4:    s = 8'h99;
			4'd5:    s = 8'h92;
			4'd6:    s = 8'h82;
			4'd7:    s = 8'hf8;
			4'd8:    s = 8'h80;
			4'd9:    s = 8'h90;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

	// Split a value below 64 into decimal tens and ones
	function automatic dec_t split_dec(input logic [5:0] v);
		dec_t       r;
		logic [5:0] rem;
		if (v >= 6'd60) begin
			r.tens = 3'd6; rem = v - 6'd60;
		end else if (v >= 6'd50) begin
			r.tens = 3'd5; rem = v - 6'd50;
		end else if (v >= 6'd40) begin
			r.tens = 3'd4; rem = v - 6'd40;
		end else if (v >= 6'd30) begin
			r.tens = 3'd3; rem = v - 6'd30;
		end else if (v >= 6'd20) begin
			r.tens = 3'd2; rem = v - 6'd20;
		end else if (v >= 6'd10) begin
			r.tens = 3'd1; rem = v - 6'd10;
		end else begin
			r.tens = 3'd0; rem = v;
		end
		r.ones = rem[3:0];
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/digital_clock_seven_segment_scan_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload
// s_*       in         tdata[3:0]: centi_tick, scan_tick, hour_key_n, minute_key_n
// m_*       out        tdata[32:0]: segments_n, digit_select_n, hours, minutes, seconds
// cfg_*     in         index 0 ticks_per_second, index 1 debounce_items
//
// One item per cycle while the output is not stalled. Each accepted item updates
// the prescaler, the time, the key debouncers and the scan position in the cycle
// it is taken; its result sits in the output register on the next cycle.
// Reset brings up 12:00:00 on digit 0, both keys released, 100 ticks per second
// and a debounce of 10 items. A stalled result holds the output register; a new
// item is taken whenever that register is empty or is being drained.

module digital_clock_seven_segment_scan_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// bits from 0: centi_tick, scan_tick, hour_key_n, minute_key_n, zero pad
	input  wire logic [7:0]  s_tdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// bits from 0: segments_n[7:0], digit_select_n[15:8], hours[20:16],
	// minutes[26:21], seconds[32:27], zero pad
	output logic [39:0]      m_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data
);
	import dcss_pkg::*;

	logic        accept;
	logic [7:0]  ticks_per_second_q;
	logic [7:0]  debounce_items_q;
	logic [2:0]  scan_q;
	logic [2:0]  scan_next;
	key_evt_t    evt;
	clock_time_t time_next;
	logic [7:0]  seg_n;
	logic [7:0]  sel_n;

	logic        out_valid_q;
	logic [7:0]  seg_q;
	logic [7:0]  sel_q;
	clock_time_t time_out_q;

	// Take a new item while the output register is empty or being drained
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// Configuration registers; the user must write them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_second_q <= TICKS_PER_SECOND_RESET;
			debounce_items_q   <= DEBOUNCE_ITEMS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TICKS_PER_SECOND: ticks_per_second_q <= cfg_data;
				CFG_DEBOUNCE_ITEMS:   debounce_items_q   <= cfg_data;
				default:              ;
			endcase
		end
	end

	// Debounce the two keys; bit 0 hour key, bit 1 minute key
	dcss_keys u_keys (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.raw_keys       ({s_tdata[3], s_tdata[2]}),
		.debounce_items (debounce_items_q),
		.evt            (evt)
	);

	// Prescaler and hh:mm:ss counters; tick first, then key adjustments
	dcss_time u_time (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.centi_tick       (s_tdata[0]),
		.ticks_per_second (ticks_per_second_q),
		.evt              (evt),
		.time_next        (time_next)
	);

	// Advance the scan, then show the digit at the new position
	assign scan_next = s_tdata[1] ? scan_q + 3'd1 : scan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			scan_q <= '0;
		else if (accept)
			scan_q <= scan_next;
	end

	dcss_display u_display (
		.time_now       (time_next),
		.position       (scan_next),
		.segments_n     (seg_n),
		.digit_select_n (sel_n)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s_tready)
			out_valid_q <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seg_q      <= seg_n;
			sel_q      <= sel_n;
			time_out_q <= time_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, time_out_q.seconds, time_out_q.minutes, time_out_q.hours,
		sel_q, seg_q};

	// Every accepted item leaves a result in the output register
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted item produced no result");

	// Exactly one digit is driven
	a_select_one_cold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot(~sel_q))
		else $error("digit select is not one-cold");

	// Time stays in range through carries and key adjustments
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (time_out_q.hours <= HOUR_MAX) &&
			(time_out_q.minutes <= MINSEC_MAX) && (time_out_q.seconds <= MINSEC_MAX))
		else $error("time out of range");

endmodule

`default_nettype wire

FILE: rtl/dcss_keys.sv
`timescale 1ns / 1ps
`default_nettype none

module dcss_keys (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [1:0]        raw_keys,
	input  wire logic [7:0]        debounce_items,
	output dcss_pkg::key_evt_t     evt
);
	import dcss_pkg::*;

	logic [1:0] stable_q;
	logic [7:0] count_q;
	logic [7:0] count_inc;
	logic       differ;
	logic       take;

	assign differ    = (raw_keys != stable_q);
	assign count_inc = (count_q == 8'hff) ? count_q : count_q + 8'd1;
	assign take      = accept && differ && (count_inc >= debounce_items);

	// Hour key has priority; a release acts too if the other key is held
	assign evt.hour_bump   = take && !raw_keys[0];
	assign evt.minute_bump = take && raw_keys[0] && !raw_keys[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= 2'b11;
			count_q  <= '0;
		end else if (accept) begin
			if (!differ) begin
				count_q <= '0;
			end else if (take) begin
				count_q  <= '0;
				stable_q <= raw_keys;
			end else begin
				count_q <= count_inc;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/dcss_time.sv
`timescale 1ns / 1ps
`default_nettype none

module dcss_time (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire logic                centi_tick,
	input  wire logic [7:0]          ticks_per_second,
	input  wire dcss_pkg::key_evt_t  evt,
	output dcss_pkg::clock_time_t    time_next
);
	import dcss_pkg::*;

	clock_time_t time_q;
	clock_time_t after_tick;
	logic [7:0]  hund_q;
	logic [7:0]  hund_inc;
	logic [7:0]  hund_next;
	logic        sec_roll;
	logic        sec_wrap;
	logic        min_wrap;
	logic        hour_wrap;

	assign hund_inc  = hund_q + 8'd1;
	assign sec_roll  = centi_tick && (hund_inc >= ticks_per_second);
	assign hund_next = sec_roll ? '0 : (centi_tick ? hund_inc : hund_q);

	// Tick carries ripple seconds -> minutes -> hours
	assign sec_wrap  = sec_roll && (time_q.seconds >= MINSEC_MAX);
	assign min_wrap  = sec_wrap && (time_q.minutes >= MINSEC_MAX);
	assign hour_wrap = min_wrap && (time_q.hours >= HOUR_MAX);

	always_comb begin
		after_tick = time_q;
		if (sec_roll)
			after_tick.seconds = sec_wrap ? '0 : time_q.seconds + 6'd1;
		if (sec_wrap)
			after_tick.minutes = min_wrap ? '0 : time_q.minutes + 6'd1;
		if (min_wrap)
			after_tick.hours = hour_wrap ? '0 : time_q.hours + 5'd1;

		// Key adjustments act on the time after the tick, minutes without carry
		time_next = after_tick;
		if (evt.hour_bump)
			time_next.hours = (after_tick.hours >= HOUR_MAX) ? '0 : after_tick.hours + 5'd1;
		if (evt.minute_bump)
			time_next.minutes = (after_tick.minutes >= MINSEC_MAX) ? '0 :
				after_tick.minutes + 6'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q.hours   <= HOUR_RESET;
			time_q.minutes <= '0;
			time_q.seconds <= '0;
			hund_q         <= '0;
		end else if (accept) begin
			time_q <= time_next;
			hund_q <= hund_next;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/dcss_display.sv
`timescale 1ns / 1ps
`default_nettype none

module dcss_display (
	input  wire dcss_pkg::clock_time_t  time_now,
	input  wire logic [2:0]             position,
	output logic [7:0]                  segments_n,
	output logic [7:0]                  digit_select_n
);
	import dcss_pkg::*;

	dec_t hour_dec;
	dec_t min_dec;
	dec_t sec_dec;

	assign hour_dec = split_dec({1'b0, time_now.hours});
	assign min_dec  = split_dec(time_now.minutes);
	assign sec_dec  = split_dec(time_now.seconds);

	// Digits left to right: h h - m m - s s; hour tens blank below ten
	always_comb begin
		case (position)
			3'd0:    segments_n = (time_now.hours > 5'd9) ?
				seg_of({1'b0, hour_dec.tens}) : SEG_BLANK;
			3'd1:    segments_n = seg_of(hour_dec.ones);
			3'd3:    segments_n = seg_of({1'b0, min_dec.tens});
			3'd4:    segments_n = seg_of(min_dec.ones);
			3'd6:    segments_n = seg_of({1'b0, sec_dec.tens});
			3'd7:    segments_n = seg_of(sec_dec.ones);
			default: segments_n = SEG_DASH;
		endcase
	end

	assign digit_select_n = ~(8'b1 << position);

endmodule

`default_nettype wire
